FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects a signal named clk, and PCPB_ASSERT_RST also arst_n, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, muted while reset is asserted.
`define PCPB_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked on every rising edge, including edges during reset.
`define PCPB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/pcpb_pkg.sv
package pcpb_pkg;

	// Result widths.
	localparam int PIX_W  = 17;
	localparam int LEN_W  = 18;
	localparam int CEN_W  = 21;
	localparam int CNT_W  = 21;
	localparam int SUM_W  = 38;
	localparam int Z_W    = 15;
	localparam int CROP_W = 20;

	// Most points that are summed and counted in one cluster.
	localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(1048576);

	// Shared divider: 43-bit dividend, 21-bit divisor, 22 quotient bits, two per cycle.
	localparam int DVD_W     = 43;
	localparam int DSR_W     = 21;
	localparam int QUO_W     = DVD_W - DSR_W;
	localparam int DIV_STEPS = QUO_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Saturation limits of a 17-bit signed pixel coordinate.
	localparam logic signed [PIX_W-1:0] PIX_MAX = 17'sh0FFFF;
	localparam logic signed [PIX_W-1:0] PIX_MIN = 17'sh10000;
	localparam logic [QUO_W-1:0] QUO_POS_LIM = QUO_W'(65535);
	localparam logic [QUO_W-1:0] QUO_NEG_LIM = QUO_W'(65536);

	// Register reset values.
	localparam logic [15:0] FOCAL_RST  = 16'd8400;
	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;
	localparam logic [7:0]  PAD_RST    = 8'd10;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_FOCAL  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_PAD    = 2'd3
	} cfg_idx_t;

	// Request to the shared divider.
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	// Response of the shared divider; quot and ovf are valid with done and hold after it.
	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: hdl/pcpb_div.sv
module pcpb_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pcpb_pkg::div_req_t  req,
	output pcpb_pkg::div_rsp_t  rsp
);
	import pcpb_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ovf_q;

	logic [DSR_W:0]    r1;
	logic [DSR_W:0]    r1n;
	logic [DSR_W:0]    r2;
	logic [DSR_W:0]    r2n;
	logic              ge1;
	logic              ge2;

	// Two restoring steps per cycle, each one compare and subtract.
	always_comb begin
		r1  = {rem_q, low_q[QUO_W-1]};
		ge1 = r1 >= {1'b0, dsr_q};
		r1n = ge1 ? r1 - {1'b0, dsr_q} : r1;
		r2  = {r1n[DSR_W-1:0], low_q[QUO_W-2]};
		ge2 = r2 >= {1'b0, dsr_q};
		r2n = ge2 ? r2 - {1'b0, dsr_q} : r2;
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder, dividend bits still to come and quotient.
	// The upper dividend part is the first partial remainder; if it already
	// reaches the divisor, the quotient does not fit and the overflow flag is set.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[DVD_W-1:QUO_W];
			low_q <= req.dividend[QUO_W-1:0];
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (step_q == '0) begin
				ovf_q <= rem_q >= dsr_q;
			end
			rem_q <= r2n[DSR_W-1:0];
			low_q <= low_q << 2;
			quo_q <= {quo_q[QUO_W-3:0], ge1, ge2};
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = quo_q;

endmodule

FILE: hdl/pcpb_crop.sv
module pcpb_crop (
	input  logic signed [pcpb_pkg::PIX_W-1:0] lo,
	input  logic signed [pcpb_pkg::PIX_W-1:0] hi,
	input  logic        [12:0]                limit,
	input  logic        [7:0]                 pad,
	output logic signed [pcpb_pkg::PIX_W-1:0] pos,
	output logic signed [pcpb_pkg::LEN_W-1:0] len
);
	import pcpb_pkg::*;

	logic signed [CROP_W-1:0] p_s;
	logic signed [CROP_W-1:0] lim_s;
	logic signed [CROP_W-1:0] x0;
	logic signed [CROP_W-1:0] xm;
	logic signed [CROP_W-1:0] x1;
	logic signed [CROP_W-1:0] w0;
	logic signed [CROP_W-1:0] e;
	logic signed [CROP_W-1:0] w1;

	// Move the left edge out by the pad if it stays on the image, then widen
	// by two pads, or by one, as far as the right edge stays inside the limit.
	always_comb begin
		p_s   = signed'(CROP_W'(pad));
		lim_s = signed'(CROP_W'(limit));
		x0    = CROP_W'(lo);
		w0    = CROP_W'(hi) - CROP_W'(lo);
		xm    = x0 - p_s;
		x1    = (xm >= 0) ? xm : x0;
		e     = x1 + w0;
		if (e + (p_s <<< 1) < lim_s) begin
			w1 = w0 + (p_s <<< 1);
		end else if (e + p_s < lim_s) begin
			w1 = w0 + p_s;
		end else begin
			w1 = w0;
		end
		pos = x1[PIX_W-1:0];
		len = w1[LEN_W-1:0];
	end

endmodule

FILE: hdl/point_cluster_projection_bbox_top.sv
// Projects cluster points to pixels and gives one box, centroid and crop result per
// cluster. A point is taken when in_ready is high and keeps the block busy while it runs,
// for u and then v, through a multiply state, a divider start state, the shared divider
// (11 steps of two quotient bits) and an accumulate state. A point marked last then runs
// two centroid divisions through the same divider and loads the result register. The
// result register is separate, so the next point is taken while a result waits on
// out_ready; only the final load of the following cluster waits for it. Configuration
// writes are taken at any time and are meant to be made while no point is in flight.
module point_cluster_projection_bbox_top #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic [14:0]            point_z,
	input  logic                   last_point,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [16:0]     box_min_u,
	output logic signed [16:0]     box_min_v,
	output logic signed [16:0]     box_max_u,
	output logic signed [16:0]     box_max_v,
	output logic signed [20:0]     centroid_u_q4,
	output logic signed [20:0]     centroid_v_q4,
	output logic signed [16:0]     crop_x,
	output logic signed [16:0]     crop_y,
	output logic signed [17:0]     crop_w,
	output logic signed [17:0]     crop_h,
	output logic [20:0]            point_count
);
	import pcpb_pkg::*;

	localparam int PW = COORD_WIDTH + 17;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_START = 8'b0000_0100,
		S_DIV   = 8'b0000_1000,
		S_ACC   = 8'b0001_0000,
		S_CEN   = 8'b0010_0000,
		S_CDIV  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic   ax_q;

	// Configuration registers.
	logic [15:0] focal_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [7:0]  pad_q;

	// Latched point.
	logic signed [COORD_WIDTH-1:0] x_q;
	logic signed [COORD_WIDTH-1:0] y_q;
	logic [Z_W-1:0]                z_q;
	logic                          last_q;

	// Cluster state.
	logic signed [SUM_W-1:0] sum_u_q;
	logic signed [SUM_W-1:0] sum_v_q;
	logic signed [PIX_W-1:0] min_u_q;
	logic signed [PIX_W-1:0] min_v_q;
	logic signed [PIX_W-1:0] max_u_q;
	logic signed [PIX_W-1:0] max_v_q;
	logic [CNT_W-1:0]        cnt_q;

	// Datapath registers.
	logic signed [PW-1:0]    prod_q;
	logic signed [PIX_W-1:0] q_q;
	logic signed [CEN_W-1:0] cen_u_q;
	logic signed [CEN_W-1:0] cen_v_q;

	// Result register.
	logic                    out_valid_q;
	logic signed [PIX_W-1:0] o_min_u_q;
	logic signed [PIX_W-1:0] o_min_v_q;
	logic signed [PIX_W-1:0] o_max_u_q;
	logic signed [PIX_W-1:0] o_max_v_q;
	logic signed [CEN_W-1:0] o_cen_u_q;
	logic signed [CEN_W-1:0] o_cen_v_q;
	logic signed [PIX_W-1:0] o_crop_x_q;
	logic signed [PIX_W-1:0] o_crop_y_q;
	logic signed [LEN_W-1:0] o_crop_w_q;
	logic signed [LEN_W-1:0] o_crop_h_q;
	logic [CNT_W-1:0]        o_cnt_q;

	logic signed [PW-1:0]    prod_c;
	logic [PW-1:0]           prj_mag;
	logic [DVD_W-1:0]        prj_dvd;
	logic signed [SUM_W-1:0] sum_sel;
	logic [SUM_W-1:0]        sum_mag;
	logic [DVD_W-1:0]        cen_dvd;
	logic signed [PIX_W-1:0] q_next;
	logic [QUO_W-1:0]        quo_neg;
	logic [11:0]             half;
	logic signed [PIX_W+1:0] diff;
	logic signed [PIX_W-1:0] val;
	logic                    room;
	logic                    in_acc;
	logic                    out_free;
	logic signed [PIX_W-1:0] cx_c;
	logic signed [PIX_W-1:0] cy_c;
	logic signed [LEN_W-1:0] cw_c;
	logic signed [LEN_W-1:0] ch_c;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == S_IDLE;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign room      = cnt_q < MAX_POINTS;

	// Configuration writes, masked to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q  <= FOCAL_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			pad_q    <= PAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_FOCAL:  focal_q  <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[12:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_PAD:    pad_q    <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	// Projection numerator and the divider operands.
	always_comb begin
		prod_c  = PW'(ax_q ? y_q : x_q) * PW'(signed'({1'b0, focal_q}));
		prj_mag = prod_q[PW-1] ? unsigned'(-prod_q) : unsigned'(prod_q);
		prj_dvd = DVD_W'(prj_mag >> 4);
		sum_sel = ax_q ? sum_v_q : sum_u_q;
		sum_mag = sum_sel[SUM_W-1] ? unsigned'(-sum_sel) : unsigned'(sum_sel);
		cen_dvd = DVD_W'({sum_mag, 4'b0000});

		div_req.start    = (state_q == S_START) || (state_q == S_CEN);
		div_req.dividend = (state_q == S_CEN) ? cen_dvd : prj_dvd;
		div_req.divisor  = (state_q == S_CEN) ? cnt_q : DSR_W'(z_q);
	end

	// Signed quotient, saturated, with zero depth giving the sign's limit, or zero for a zero product.
	always_comb begin
		quo_neg = ~div_rsp.quot + 1'b1;
		if (z_q == '0) begin
			if (prod_q == '0) begin
				q_next = '0;
			end else if (prod_q[PW-1]) begin
				q_next = PIX_MIN;
			end else begin
				q_next = PIX_MAX;
			end
		end else if (prod_q[PW-1]) begin
			q_next = (div_rsp.ovf || div_rsp.quot > QUO_NEG_LIM) ? PIX_MIN :
				signed'(quo_neg[PIX_W-1:0]);
		end else begin
			q_next = (div_rsp.ovf || div_rsp.quot > QUO_POS_LIM) ? PIX_MAX :
				signed'(div_rsp.quot[PIX_W-1:0]);
		end
	end

	// Pixel coordinate: half the image size minus the quotient, saturated.
	always_comb begin
		half = ax_q ? height_q[12:1] : width_q[12:1];
		diff = signed'((PIX_W+2)'(half)) - (PIX_W+2)'(q_q);
		if (diff > (PIX_W+2)'(PIX_MAX)) begin
			val = PIX_MAX;
		end else if (diff < (PIX_W+2)'(PIX_MIN)) begin
			val = PIX_MIN;
		end else begin
			val = diff[PIX_W-1:0];
		end
	end

	pcpb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pcpb_crop u_crop_u (
		.lo    (min_u_q),
		.hi    (max_u_q),
		.limit (width_q),
		.pad   (pad_q),
		.pos   (cx_c),
		.len   (cw_c)
	);

	pcpb_crop u_crop_v (
		.lo    (min_v_q),
		.hi    (max_v_q),
		.limit (height_q),
		.pad   (pad_q),
		.pos   (cy_c),
		.len   (ch_c)
	);

	// Sequencer and cluster state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= 1'b0;
			sum_u_q     <= '0;
			sum_v_q     <= '0;
			cnt_q       <= '0;
			min_u_q     <= PIX_W'(WIDTH_RST);
			min_v_q     <= PIX_W'(HEIGHT_RST);
			max_u_q     <= '0;
			max_v_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register fills in the output state and empties on a handshake.
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						// A new cluster starts its box from the current image size.
						if (cnt_q == '0) begin
							min_u_q <= PIX_W'(width_q);
							min_v_q <= PIX_W'(height_q);
							max_u_q <= '0;
							max_v_q <= '0;
						end
						ax_q    <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (!ax_q) begin
						if (val < min_u_q) min_u_q <= val;
						if (val > max_u_q) max_u_q <= val;
						if (room) sum_u_q <= sum_u_q + SUM_W'(val);
						ax_q    <= 1'b1;
						state_q <= S_MUL;
					end else begin
						if (val < min_v_q) min_v_q <= val;
						if (val > max_v_q) max_v_q <= val;
						if (room) begin
							sum_v_q <= sum_v_q + SUM_W'(val);
							cnt_q   <= cnt_q + 1'b1;
						end
						ax_q    <= 1'b0;
						state_q <= last_q ? S_CEN : S_IDLE;
					end
				end
				S_CEN: begin
					state_q <= S_CDIV;
				end
				S_CDIV: begin
					if (div_rsp.done) begin
						ax_q    <= 1'b1;
						state_q <= ax_q ? S_OUT : S_CEN;
					end
				end
				S_OUT: begin
					// Hand the result over and clear the cluster.
					if (out_free) begin
						sum_u_q     <= '0;
						sum_v_q     <= '0;
						cnt_q       <= '0;
						ax_q        <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Point, product, quotient and centroid registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= point_x;
			y_q    <= point_y;
			z_q    <= point_z;
			last_q <= last_point;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_c;
		end
		if (state_q == S_DIV && div_rsp.done) begin
			q_q <= q_next;
		end
		if (state_q == S_CDIV && div_rsp.done) begin
			if (ax_q) begin
				cen_v_q <= sum_sel[SUM_W-1] ? signed'(quo_neg[CEN_W-1:0]) :
					signed'(div_rsp.quot[CEN_W-1:0]);
			end else begin
				cen_u_q <= sum_sel[SUM_W-1] ? signed'(quo_neg[CEN_W-1:0]) :
					signed'(div_rsp.quot[CEN_W-1:0]);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			o_min_u_q  <= min_u_q;
			o_min_v_q  <= min_v_q;
			o_max_u_q  <= max_u_q;
			o_max_v_q  <= max_v_q;
			o_cen_u_q  <= cen_u_q;
			o_cen_v_q  <= cen_v_q;
			o_crop_x_q <= cx_c;
			o_crop_y_q <= cy_c;
			o_crop_w_q <= cw_c;
			o_crop_h_q <= ch_c;
			o_cnt_q    <= cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign box_min_u     = o_min_u_q;
	assign box_min_v     = o_min_v_q;
	assign box_max_u     = o_max_u_q;
	assign box_max_v     = o_max_v_q;
	assign centroid_u_q4 = o_cen_u_q;
	assign centroid_v_q4 = o_cen_v_q;
	assign crop_x        = o_crop_x_q;
	assign crop_y        = o_crop_y_q;
	assign crop_w        = o_crop_w_q;
	assign crop_h        = o_crop_h_q;
	assign point_count   = o_cnt_q;

endmodule

FILE: hdl/pcpb_chk.sv
`include "assert_macros.svh"

module pcpb_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [16:0] box_min_u,
	input logic signed [16:0] box_max_u,
	input logic [20:0]        point_count
);

	// No result is offered while reset is held.
	`PCPB_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !out_valid, "result valid during reset")

	// A point keeps the block busy, so in_ready is low in the cycle after it is taken.
	`PCPB_ASSERT_RST(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after a point")

	// Every finished cluster holds at least one point.
	`PCPB_ASSERT_RST(a_count_nonzero, out_valid |-> point_count != 21'd0, "empty cluster result")

	// Each point lowers the minimum or raises the maximum to reach it, so the u box is never inverted.
	`PCPB_ASSERT_RST(a_box_order, out_valid |-> box_min_u <= box_max_u, "box min above max")

	// A stalled result holds.
	`PCPB_ASSERT_RST(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(point_count), "stalled result changed")

endmodule

bind point_cluster_projection_bbox_top pcpb_chk u_pcpb_chk (.*);

FILE: tb/point_cluster_projection_bbox_top_tb.sv
module point_cluster_projection_bbox_top_tb;
	import pcpb_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 700;

	// One finished cluster as it leaves the block.
	typedef struct packed {
		logic signed [16:0] min_u;
		logic signed [16:0] min_v;
		logic signed [16:0] max_u;
		logic signed [16:0] max_v;
		logic signed [20:0] cen_u;
		logic signed [20:0] cen_v;
		logic signed [16:0] crop_x;
		logic signed [16:0] crop_y;
		logic signed [17:0] crop_w;
		logic signed [17:0] crop_h;
		logic [20:0]        count;
	} cluster_box_t;

	// One directed point; typed rows carry a box worked out by hand.
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        z;
		logic               last;
		bit                 typed;
		cluster_box_t       box;
	} point_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic [14:0] point_z;
	logic last_point;
	logic out_valid;
	logic out_ready;
	logic signed [16:0] box_min_u;
	logic signed [16:0] box_min_v;
	logic signed [16:0] box_max_u;
	logic signed [16:0] box_max_v;
	logic signed [20:0] centroid_u_q4;
	logic signed [20:0] centroid_v_q4;
	logic signed [16:0] crop_x;
	logic signed [16:0] crop_y;
	logic signed [17:0] crop_w;
	logic signed [17:0] crop_h;
	logic [20:0] point_count;

	// Register copies used for prediction.
	logic [15:0] focal;
	logic [12:0] img_w;
	logic [12:0] img_h;
	logic [7:0]  pad;

	// Cluster accumulation state of the predictor.
	longint acc_u;
	longint acc_v;
	longint lo_u;
	longint lo_v;
	longint hi_u;
	longint hi_v;
	int     npts;

	cluster_box_t pending_boxes[$];
	int err_count;
	int boxes_seen;
	bit steady;
	bit hold_done;
	int hold_left;
	int rx_gap;

	string field_names [11] = '{"box_min_u", "box_min_v", "box_max_u", "box_max_v",
		"centroid_u_q4", "centroid_v_q4", "crop_x", "crop_y", "crop_w", "crop_h",
		"point_count"};

	point_cluster_projection_bbox_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.last_point(last_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.box_min_u(box_min_u),
		.box_min_v(box_min_v),
		.box_max_u(box_max_u),
		.box_max_v(box_max_v),
		.centroid_u_q4(centroid_u_q4),
		.centroid_v_q4(centroid_v_q4),
		.crop_x(crop_x),
		.crop_y(crop_y),
		.crop_w(crop_w),
		.crop_h(crop_h),
		.point_count(point_count)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog that ends a run which stops making progress.
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("point_cluster_projection_bbox_top_tb NOT OK");
		$finish;
	end

	// Clamp to the 17-bit signed pixel range.
	function automatic longint sat_pix(input longint v);
		if (v < -65536) return -65536;
		if (v > 65535) return 65535;
		return v;
	endfunction

	// Pinhole quotient coord * focal / (16 * z), truncated and saturated.
	function automatic longint project_coord(input longint c, input longint z);
		longint num;
		longint den;
		num = c * longint'(focal);
		den = z * 16;
		if (den == 0) begin
			if (num > 0) return 65535;
			if (num < 0) return -65536;
			return 0;
		end
		return sat_pix(num / den);
	endfunction

	// Shift the box edge left by the margin when it stays on the image, then widen
	// by two margins, one margin or none, whichever still ends inside the image.
	function automatic void pad_span(input longint lo, input longint hi, input longint limit,
		output longint pos, output longint len);
		longint p;
		p = longint'(pad);
		pos = lo;
		len = hi - lo;
		if (pos - p >= 0) pos -= p;
		if (pos + len + 2 * p < limit) len += 2 * p;
		else if (pos + len + p < limit) len += p;
	endfunction

	function automatic void clear_cluster();
		acc_u = 0;
		acc_v = 0;
		lo_u = longint'(img_w);
		lo_v = longint'(img_h);
		hi_u = 0;
		hi_v = 0;
		npts = 0;
	endfunction

	// Append a closed cluster to the expected results.
	function automatic void queue_box(input cluster_box_t b);
		pending_boxes = {pending_boxes, b};
	endfunction

	// Fold one point into the running cluster and produce the box on the last point.
	function automatic void absorb_point(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic [14:0] z, input logic last, output bit done, output cluster_box_t box);
		longint u;
		longint v;
		longint pos;
		longint len;
		if (npts == 0) begin
			lo_u = longint'(img_w);
			lo_v = longint'(img_h);
			hi_u = 0;
			hi_v = 0;
		end
		u = sat_pix(longint'(img_w >> 1) - project_coord(longint'(x), longint'(z)));
		v = sat_pix(longint'(img_h >> 1) - project_coord(longint'(y), longint'(z)));
		if (u < lo_u) lo_u = u;
		if (u > hi_u) hi_u = u;
		if (v < lo_v) lo_v = v;
		if (v > hi_v) hi_v = v;
		// Once the count is full, points only widen the box.
		if (npts < int'(MAX_POINTS)) begin
			acc_u += u;
			acc_v += v;
			npts++;
		end
		done = last;
		box = '0;
		if (last) begin
			box.min_u = 17'(lo_u);
			box.min_v = 17'(lo_v);
			box.max_u = 17'(hi_u);
			box.max_v = 17'(hi_v);
			box.cen_u = 21'((acc_u * 16) / longint'(npts));
			box.cen_v = 21'((acc_v * 16) / longint'(npts));
			pad_span(lo_u, hi_u, longint'(img_w), pos, len);
			box.crop_x = 17'(pos);
			box.crop_w = 18'(len);
			pad_span(lo_v, hi_v, longint'(img_h), pos, len);
			box.crop_y = 17'(pos);
			box.crop_h = 18'(len);
			box.count = 21'(npts);
			clear_cluster();
		end
	endfunction

	function automatic void unpack_box(input cluster_box_t b, output longint f [11]);
		f[0] = longint'(b.min_u);
		f[1] = longint'(b.min_v);
		f[2] = longint'(b.max_u);
		f[3] = longint'(b.max_v);
		f[4] = longint'(b.cen_u);
		f[5] = longint'(b.cen_v);
		f[6] = longint'(b.crop_x);
		f[7] = longint'(b.crop_y);
		f[8] = longint'(b.crop_w);
		f[9] = longint'(b.crop_h);
		f[10] = longint'(b.count);
	endfunction

	// Compare the box on the outputs with the oldest pending cluster.
	function automatic void check_next_box();
		cluster_box_t act;
		cluster_box_t exp_box;
		longint ev [11];
		longint av [11];
		act = {box_min_u, box_min_v, box_max_u, box_max_v, centroid_u_q4, centroid_v_q4,
			crop_x, crop_y, crop_w, crop_h, point_count};
		boxes_seen++;
		if (pending_boxes.size() == 0) begin
			if (err_count < 10) $display("unexpected box, no cluster was closed");
			err_count++;
			return;
		end
		exp_box = pending_boxes.pop_front();
		unpack_box(exp_box, ev);
		unpack_box(act, av);
		for (int i = 0; i < 11; i++) begin
			if (ev[i] != av[i]) begin
				if (err_count < 10)
					$display("box %0d mismatch in %s: expected %0d, got %0d",
						boxes_seen, field_names[i], ev[i], av[i]);
				err_count++;
			end
		end
	endfunction

	// Result side: check accepted boxes and drive out_ready with random stalls,
	// plus one long hold-off that backs the block up.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) check_next_box();
			if (!hold_done && boxes_seen >= 40) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else if (!steady && $urandom_range(99) < 4) begin
				rx_gap = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one point, wait for it to be taken and predict its effect.
	// Valid is left high so the next point can follow without a gap.
	task automatic offer_point(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic [14:0] z, input logic last, input bit typed, input cluster_box_t typed_box);
		cluster_box_t box;
		bit done;
		if (!steady && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 45)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		last_point <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		absorb_point(x, y, z, last, done, box);
		if (done) queue_box(typed ? typed_box : box);
	endtask

	// Write one register and mirror it; valid stays high for the next write.
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_FOCAL: focal = d;
			REG_WIDTH: img_w = d[12:0];
			REG_HEIGHT: img_h = d[12:0];
			REG_PAD: pad = d[7:0];
		endcase
	endtask

	// Reprogram all registers once the block has drained.
	task automatic program_regs(input logic [15:0] f, input logic [15:0] w,
		input logic [15:0] h, input logic [15:0] p);
		while (pending_boxes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_FOCAL, f);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_PAD, p);
		cfg_valid <= 1'b0;
	endtask

	// Random clusters: mostly compact objects in front of the camera, some noise
	// clusters with raw field values and near-zero depth. The last cluster is closed.
	task automatic run_phase(input int n_points);
		int left;
		int size;
		int k;
		int cx;
		int cy;
		int cz;
		int jit;
		bit tidy;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] z;
		left = n_points;
		while (left > 0) begin
			size = int'(($urandom_range(99) < 85) ? $urandom_range(1, 6) :
				$urandom_range(7, 40));
			if (size > left) size = left;
			tidy = $urandom_range(99) < 70;
			cx = int'($urandom_range(0, 8000)) - 4000;
			cy = int'($urandom_range(0, 8000)) - 4000;
			cz = int'($urandom_range(300, 12000));
			jit = int'($urandom_range(0, 600));
			for (k = 0; k < size; k++) begin
				if (tidy) begin
					x = 16'(cx + int'($urandom_range(0, 2 * jit)) - jit);
					y = 16'(cy + int'($urandom_range(0, 2 * jit)) - jit);
					z = 15'(cz + int'($urandom_range(0, 400)) - 200);
				end else begin
					x = 16'($urandom);
					y = 16'($urandom);
					z = 15'(($urandom_range(99) < 12) ? $urandom_range(0, 3) : $urandom);
				end
				offer_point(x, y, z, k == size - 1, 1'b0, '0);
			end
			left -= size;
		end
		in_valid <= 1'b0;
	endtask

	// Main sequence: reset, directed table, then random phases over several settings.
	initial begin
		point_row_t rows [19];
		cluster_box_t centered;
		cluster_box_t railed;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FOCAL;
		cfg_data <= '0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		point_z <= '0;
		last_point <= 1'b0;
		focal = FOCAL_RST;
		img_w = WIDTH_RST;
		img_h = HEIGHT_RST;
		pad = PAD_RST;
		clear_cluster();
		err_count = 0;
		boxes_seen = 0;
		steady = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		rx_gap = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// A point on the optical axis lands on the image center.
		centered = {17'sd320, 17'sd240, 17'sd320, 17'sd240, 21'sd5120, 21'sd3840,
			17'sd310, 17'sd230, 18'sd20, 18'sd20, 21'd1};
		// Zero depth with x positive and y negative drives both quotients to the rails.
		railed = {-17'sd65215, 17'sd480, 17'sd0, 17'sd65535, -21'sd1043440, 21'sd1048560,
			-17'sd65215, 17'sd470, 18'sd65235, 18'sd65055, 21'd1};

		rows = '{
			'{16'sd0, 16'sd0, 15'd1000, 1'b1, 1'b1, centered},
			'{16'sd0, 16'sd0, 15'd0, 1'b1, 1'b1, centered},
			'{16'sd100, -16'sd100, 15'd0, 1'b1, 1'b1, railed},
			'{-16'sd100, 16'sd100, 15'd0, 1'b1, 1'b0, '0},
			'{16'sd32767, 16'sd32767, 15'd1, 1'b0, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 15'd1, 1'b0, 1'b0, '0},
			'{16'sd32767, 16'sh8000, 15'd32767, 1'b0, 1'b0, '0},
			'{16'sh8000, 16'sd32767, 15'd32767, 1'b1, 1'b0, '0},
			'{16'sh8000, 16'sh8000, 15'd0, 1'b1, 1'b0, '0},
			'{-16'sd500, -16'sd400, 15'd1000, 1'b0, 1'b0, '0},
			'{16'sd500, 16'sd400, 15'd1000, 1'b0, 1'b0, '0},
			'{16'sd0, 16'sd0, 15'd2000, 1'b1, 1'b0, '0},
			'{-16'sd600, -16'sd450, 15'd1000, 1'b0, 1'b0, '0},
			'{-16'sd590, -16'sd440, 15'd1010, 1'b1, 1'b0, '0},
			'{16'sd600, 16'sd450, 15'd1000, 1'b1, 1'b0, '0},
			'{16'sd1, 16'sd1, 15'd32767, 1'b1, 1'b0, '0},
			'{-16'sd1, -16'sd1, 15'd1, 1'b1, 1'b0, '0},
			'{16'sd0, 16'sd0, 15'd16384, 1'b0, 1'b0, '0},
			'{16'sd21845, -16'sd21846, 15'd10922, 1'b1, 1'b0, '0}
		};
		foreach (rows[i])
			offer_point(rows[i].x, rows[i].y, rows[i].z, rows[i].last, rows[i].typed,
				rows[i].box);
		in_valid <= 1'b0;

		// Largest focal length and image with the widest margin.
		program_regs(16'd65535, 16'd4096, 16'd4096, 16'd255);
		run_phase(200);
		// Smallest legal settings.
		program_regs(16'd1, 16'd2, 16'd2, 16'd0);
		run_phase(190);
		// Out-of-range values; the upper data bits are dropped by the registers.
		program_regs(16'd0, 16'hFFFF, 16'hE000, 16'hFF80);
		run_phase(190);
		// Reset settings with no idling on either side.
		program_regs(FOCAL_RST, 16'(WIDTH_RST), 16'(HEIGHT_RST), 16'(PAD_RST));
		steady = 1'b1;
		run_phase(200);
		steady = 1'b0;
		// Random legal settings.
		program_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(2, 4096)),
			16'($urandom_range(2, 4096)), 16'($urandom_range(0, 255)));
		run_phase(200);
		program_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(2, 4096)),
			16'($urandom_range(2, 4096)), 16'($urandom_range(0, 255)));
		run_phase(200);

		// Drain and let the block settle before the verdict.
		while (pending_boxes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("point_cluster_projection_bbox_top_tb OK");
		end else begin
			$display("point_cluster_projection_bbox_top_tb NOT OK");
		end
		$finish;
	end

endmodule
